// ----- sv/prd_pkg.sv -----
`timescale 1ns / 1ps

package prd_pkg;

   // payload widths
   localparam int unsigned RANK_W = 10;
   localparam int unsigned POS_W  = 10;
   localparam int unsigned ELEM_W = 10;
   localparam int unsigned SIZE_W = 11;

   // used map is kept as rows of this many flags
   localparam int unsigned WORD_W = 32;
   localparam int unsigned OFF_W  = $clog2(WORD_W);
   localparam int unsigned POP_W  = $clog2(WORD_W + 1);

   localparam int unsigned MAX_SIZE_DEF = 1024;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   // csr port
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-3:0] REG_PERM_SIZE = 1'b0;

endpackage

// ----- sv/prd_ram.sv -----
`timescale 1ns / 1ps

module prd_ram #(
   parameter int unsigned WIDTH = prd_pkg::WORD_W,
   parameter int unsigned DEPTH = 32,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/permutation_rank_decoder.sv -----
`timescale 1ns / 1ps

// Permutation rank decoder: rebuilds a permutation from a stream of ranks.
// req channel: one rank per beat, the rank-th still unused element (from zero).
// rsp channel: position, element, last and error per beat. The rank for the
// next-to-last position yields two beats, the second carrying the single
// remaining element with last set. A rank not below the unused count gives one
// beat with error set. After an error or a last beat a new permutation begins.
// csr port: perm_size at byte address 0, clamped to 2..MAX_SIZE; writing it
// starts a new permutation. Write only while the block is idle.
// Flow: req_ready is high only while idle. An item runs one accept step, r + 1
// scan steps (one row per cycle through the map RAM), r being the number of
// 32-flag map rows scanned until the chosen element is found, a 5-step halving
// search inside the row and one emit step; a rank that is too large goes from
// accept straight to the emit step. The next-to-last item runs a second scan
// for the remaining element.
// The result sits in an output register; a stalled receiver holds the block
// in its emit step until the beat is taken. Reset sets perm_size to 1024 and
// clears the used map at once through per-row valid flags (no clearing pass).

module permutation_rank_decoder #(
   parameter int unsigned MAX_SIZE = prd_pkg::MAX_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [prd_pkg::RANK_W-1:0]      req_rank,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [prd_pkg::POS_W-1:0]       rsp_position,
   output logic [prd_pkg::ELEM_W-1:0]      rsp_element,
   output logic                            rsp_last,
   output logic                            rsp_error,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [prd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [prd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [prd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   import prd_pkg::*;

   localparam int unsigned IDX_W = $clog2(MAX_SIZE);
   localparam int unsigned CNT_W = $clog2(MAX_SIZE + 1);
   localparam int unsigned CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;
   localparam int unsigned NROWS = (MAX_SIZE + WORD_W - 1) / WORD_W;
   localparam int unsigned ROW_W = (NROWS > 1) ? $clog2(NROWS) : 1;
   localparam int unsigned SH_W  = OFF_W + 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_NARROW = 3'd2;
   localparam logic [2:0] ST_EMIT   = 3'd3;

   logic [2:0]         state_ff, state_in;
   logic [SIZE_W-1:0]  perm_ff, perm_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [NROWS-1:0]   row_valid_ff, row_valid_in;
   logic [RANK_W-1:0]  k_ff, k_in;
   logic               final_ff, final_in;
   logic [ROW_W-1:0]   rd_row_ff, rd_row_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [ROW_W-1:0]   chk_row_ff, chk_row_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [WORD_W-1:0]  frag_ff, frag_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [OFF_W-1:0]   half_ff, half_in;
   logic [IDX_W-1:0]   res_pos_ff, res_pos_in;
   logic [ELEM_W-1:0]  res_elem_ff, res_elem_in;
   logic               res_last_ff, res_last_in;
   logic               res_err_ff, res_err_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [ELEM_W-1:0]  rsp_elem_ff, rsp_elem_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_err_ff, rsp_err_in;

   logic               ram_wr_en;
   logic [ROW_W-1:0]   ram_wr_addr;
   logic [WORD_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [WORD_W-1:0]  ram_rd_data;

   logic [CNT_W-1:0]   size_eff;
   logic               accept;
   logic               csr_hit;
   logic               csr_wr;
   logic               wrap;
   logic [IDX_W-1:0]   pos_eff;
   logic [CNT_W-1:0]   remaining;
   logic [WORD_W-1:0]  chk_word;
   logic [WORD_W-1:0]  chk_free;
   logic [POP_W-1:0]   chk_cnt;
   logic [WORD_W-1:0]  lo_frag;
   logic [POP_W-1:0]   lo_cnt;
   logic               go_low;
   logic [OFF_W-1:0]   off_next;

   prd_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NROWS),
      .AW    (ROW_W)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_row_ff),
      .rd_data (ram_rd_data)
   );

   // clamp the register to 2..MAX_SIZE
   always_comb begin
      if (perm_ff < SIZE_W'(2)) begin
         size_eff = CNT_W'(2);
      end else if (32'(perm_ff) > MAX_SIZE) begin
         size_eff = CNT_W'(MAX_SIZE);
      end else begin
         size_eff = CNT_W'(perm_ff);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_hit   = (csr_paddr[CSR_ADDR_W-1:2] == REG_PERM_SIZE);
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite && csr_hit;

   // stale position check and remaining count at accept
   assign wrap      = (CNT_W'(pos_ff) + CNT_W'(1)) >= size_eff;
   assign pos_eff   = wrap ? '0 : pos_ff;
   assign remaining = size_eff - CNT_W'(pos_eff);

   // row check: count free flags of the row read last cycle
   assign chk_word = row_valid_ff[chk_row_ff] ? ram_rd_data : '0;
   assign chk_free = ~chk_word;
   assign chk_cnt  = POP_W'($countones(chk_free));

   // halving step inside the chosen row
   assign lo_frag  = frag_ff & ({WORD_W{1'b1}} >> (SH_W'(WORD_W) - SH_W'(half_ff)));
   assign lo_cnt   = POP_W'($countones(lo_frag));
   assign go_low   = k_ff < RANK_W'(lo_cnt);
   assign off_next = go_low ? off_ff : off_ff + half_ff;

   always_comb begin
      state_in     = state_ff;
      perm_in      = perm_ff;
      pos_in       = pos_ff;
      row_valid_in = row_valid_ff;
      k_in         = k_ff;
      final_in     = final_ff;
      rd_row_in    = rd_row_ff;
      chk_valid_in = chk_valid_ff;
      chk_row_in   = chk_row_ff;
      word_in      = word_ff;
      frag_in      = frag_ff;
      row_in       = row_ff;
      off_in       = off_ff;
      half_in      = half_ff;
      res_pos_in   = res_pos_ff;
      res_elem_in  = res_elem_ff;
      res_last_in  = res_last_ff;
      res_err_in   = res_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_elem_in  = rsp_elem_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = row_ff;
      ram_wr_data  = word_ff | (WORD_W'(1) << off_next);
      ram_rd_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pos_in = pos_eff;
               if (wrap) begin
                  row_valid_in = '0;
               end
               if (CMP_W'(req_rank) >= CMP_W'(remaining)) begin
                  res_pos_in  = pos_eff;
                  res_elem_in = '0;
                  res_last_in = 1'b0;
                  res_err_in  = 1'b1;
                  state_in    = ST_EMIT;
               end else begin
                  k_in         = req_rank;
                  final_in     = 1'b0;
                  rd_row_in    = '0;
                  chk_valid_in = 1'b0;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // read one row per cycle, check it the cycle after
            ram_rd_en    = 1'b1;
            chk_valid_in = 1'b1;
            chk_row_in   = rd_row_ff;
            if (rd_row_ff != ROW_W'(NROWS - 1)) begin
               rd_row_in = rd_row_ff + ROW_W'(1);
            end
            if (chk_valid_ff) begin
               if (k_ff < RANK_W'(chk_cnt)) begin
                  word_in      = chk_word;
                  frag_in      = chk_free;
                  row_in       = chk_row_ff;
                  off_in       = '0;
                  half_in      = OFF_W'(WORD_W / 2);
                  chk_valid_in = 1'b0;
                  state_in     = ST_NARROW;
               end else begin
                  k_in = k_ff - RANK_W'(chk_cnt);
               end
            end
         end
         ST_NARROW: begin
            if (go_low) begin
               frag_in = lo_frag;
            end else begin
               frag_in = frag_ff >> half_ff;
               k_in    = k_ff - RANK_W'(lo_cnt);
            end
            off_in  = off_next;
            half_in = half_ff >> 1;
            if (half_ff == OFF_W'(1)) begin
               ram_wr_en            = 1'b1;
               row_valid_in[row_ff] = 1'b1;
               res_pos_in           = pos_ff;
               res_elem_in          = ELEM_W'({row_ff, off_next});
               res_last_in          = final_ff;
               res_err_in           = 1'b0;
               state_in             = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = POS_W'(res_pos_ff);
               rsp_elem_in  = res_elem_ff;
               rsp_last_in  = res_last_ff;
               rsp_err_in   = res_err_ff;
               if (res_err_ff || res_last_ff) begin
                  row_valid_in = '0;
                  pos_in       = '0;
                  state_in     = ST_IDLE;
               end else begin
                  pos_in = pos_ff + IDX_W'(1);
                  // one element left: scan for the lowest free one
                  if ((CNT_W'(pos_ff) + CNT_W'(2)) == size_eff) begin
                     k_in         = '0;
                     final_in     = 1'b1;
                     rd_row_in    = '0;
                     chk_valid_in = 1'b0;
                     state_in     = ST_SCAN;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr) begin
         perm_in      = csr_pwdata[SIZE_W-1:0];
         row_valid_in = '0;
         pos_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         perm_ff      <= SIZE_RESET;
         pos_ff       <= '0;
         row_valid_ff <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         perm_ff      <= perm_in;
         pos_ff       <= pos_in;
         row_valid_ff <= row_valid_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      final_ff    <= final_in;
      rd_row_ff   <= rd_row_in;
      chk_row_ff  <= chk_row_in;
      word_ff     <= word_in;
      frag_ff     <= frag_in;
      row_ff      <= row_in;
      off_ff      <= off_in;
      half_ff     <= half_in;
      res_pos_ff  <= res_pos_in;
      res_elem_ff <= res_elem_in;
      res_last_ff <= res_last_in;
      res_err_ff  <= res_err_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_elem_ff <= rsp_elem_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_element  = rsp_elem_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_error    = rsp_err_ff;

   assign csr_prdata = csr_hit ? CSR_DATA_W'(perm_ff) : '0;
   assign csr_pready = 1'b1;

endmodule

// ----- dv/prd_checker.sv -----
`timescale 1ns / 1ps

module prd_checker #(
   parameter int unsigned MAX_SIZE = prd_pkg::MAX_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [prd_pkg::RANK_W-1:0]      req_rank,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [prd_pkg::POS_W-1:0]       rsp_position,
   input  logic [prd_pkg::ELEM_W-1:0]      rsp_element,
   input  logic                            rsp_last,
   input  logic                            rsp_error,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [prd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [prd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  logic                            csr_pready,
   output int unsigned                     mismatch_count,
   output int unsigned                     pending_count
);

   import prd_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] PERM_SIZE_ADDR = {REG_PERM_SIZE, 2'b00};

   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic [ELEM_W-1:0] element;
      logic              last;
      logic              error;
   } perm_beat_type;

   perm_beat_type     expected_beats[$];
   bit                taken[MAX_SIZE];
   int unsigned       fill_pos;
   logic [SIZE_W-1:0] size_setting;
   int unsigned       bad_beats;

   function automatic int unsigned clamp_size(logic [SIZE_W-1:0] raw);
      int unsigned n;
      n = 32'(raw);
      if (n < 2) n = 2;
      if (n > MAX_SIZE) n = MAX_SIZE;
      return n;
   endfunction

   function automatic void clear_map();
      foreach (taken[i]) taken[i] = 1'b0;
      fill_pos = 0;
   endfunction

   // k-th free element counted from zero, n when there is none
   function automatic int unsigned nth_free(int unsigned k, int unsigned n);
      int unsigned seen;
      seen = 0;
      for (int unsigned e = 0; e < n; e++) begin
         if (!taken[e]) begin
            if (seen == k) return e;
            seen++;
         end
      end
      return n;
   endfunction

   function automatic void decode_rank(logic [RANK_W-1:0] rank);
      int unsigned   n;
      int unsigned   left;
      int unsigned   pick;
      perm_beat_type beat;
      n = clamp_size(size_setting);
      if (fill_pos + 1 >= n) clear_map();
      left = n - fill_pos;
      beat.position = POS_W'(fill_pos);
      beat.element = '0;
      beat.last = 1'b0;
      beat.error = 1'b0;
      pick = (32'(rank) >= left) ? n : nth_free(32'(rank), n);
      if (pick >= n) begin
         beat.error = 1'b1;
         expected_beats.push_back(beat);
         clear_map();
         return;
      end
      taken[pick] = 1'b1;
      beat.element = ELEM_W'(pick);
      expected_beats.push_back(beat);
      fill_pos++;
      if (fill_pos + 1 == n) begin
         // one element left, it closes the permutation
         pick = nth_free(0, n);
         if (pick >= n) pick = 0;
         beat.position = POS_W'(fill_pos);
         beat.element = ELEM_W'(pick);
         beat.last = 1'b1;
         expected_beats.push_back(beat);
         clear_map();
      end
   endfunction

   always @(posedge clock) begin
      perm_beat_type want;
      perm_beat_type got;
      if (reset) begin
         size_setting = SIZE_RESET;
         clear_map();
         expected_beats.delete();
         bad_beats = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_position, rsp_element, rsp_last, rsp_error};
            if (expected_beats.size() == 0) begin
               if (bad_beats < 10)
                  $display("%0t: unexpected beat pos=%0d elem=%0d last=%0b err=%0b",
                           $realtime, got.position, got.element, got.last, got.error);
               bad_beats++;
            end else begin
               want = expected_beats.pop_front();
               if (got.position != want.position || got.element != want.element ||
                   got.last != want.last || got.error != want.error) begin
                  if (bad_beats < 10)
                     $display({"%0t: mismatch exp pos=%0d elem=%0d last=%0b err=%0b,",
                               " got pos=%0d elem=%0d last=%0b err=%0b"},
                              $realtime, want.position, want.element, want.last,
                              want.error, got.position, got.element, got.last,
                              got.error);
                  bad_beats++;
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == PERM_SIZE_ADDR) begin
            size_setting = csr_pwdata[SIZE_W-1:0];
            clear_map();
         end
         if (req_valid && req_ready) decode_rank(req_rank);
      end
      mismatch_count <= bad_beats;
      pending_count <= expected_beats.size();
   end

endmodule

// ----- dv/tb_permutation_rank_decoder.sv -----
`timescale 1ns / 1ps

module tb_permutation_rank_decoder;

   import prd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam logic [CSR_ADDR_W-1:0] PERM_SIZE_ADDR = {REG_PERM_SIZE, 2'b00};
   // decodes to no register, a write there must change nothing
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = 3'd4;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [RANK_W-1:0]      req_rank = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [POS_W-1:0]       rsp_position;
   logic [ELEM_W-1:0]      rsp_element;
   logic                   rsp_last;
   logic                   rsp_error;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int unsigned mismatch_count;
   int unsigned pending_count;

   // stimulus-side view of the permutation, only used to shape ranks
   int unsigned stim_size = 1024;
   int unsigned stim_pos = 0;
   int unsigned burst_left = 0;

   // receiver stall pattern
   int unsigned seg_left = 0;
   int unsigned stall_mode = 0;
   int unsigned run_left = 0;
   bit          hold_hi = 1'b0;

   always #1 clock = ~clock;

   permutation_rank_decoder u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rank     (req_rank),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_position (rsp_position),
      .rsp_element  (rsp_element),
      .rsp_last     (rsp_last),
      .rsp_error    (rsp_error),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   prd_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rank       (req_rank),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_position   (rsp_position),
      .rsp_element    (rsp_element),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always @(negedge clock) begin
      if (seg_left == 0) begin
         seg_left = $urandom_range(20, 200);
         stall_mode = $urandom_range(0, 3);
      end
      seg_left--;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: begin
            if (run_left == 0) begin
               run_left = $urandom_range(1, 16);
               hold_hi = !hold_hi;
            end
            run_left--;
            rsp_ready <= hold_hi;
         end
      endcase
   end

   task automatic idle_cycles(input int unsigned n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // drop valid and hold off until every expected beat has come back
   task automatic wait_quiet();
      idle_cycles(1);
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_size(input logic [CSR_DATA_W-1:0] data);
      int unsigned n;
      wait_quiet();
      csr_write(PERM_SIZE_ADDR, data);
      n = data[SIZE_W-1:0];
      if (n < 2) n = 2;
      if (n > MAX_SIZE_DEF) n = MAX_SIZE_DEF;
      stim_size = n;
      stim_pos = 0;
   endtask

   function automatic void track_rank(input logic [RANK_W-1:0] rank);
      if (stim_pos + 1 >= stim_size) stim_pos = 0;
      if (rank >= stim_size - stim_pos) begin
         stim_pos = 0;
      end else begin
         stim_pos++;
         if (stim_pos + 1 == stim_size) stim_pos = 0;
      end
   endfunction

   function automatic logic [RANK_W-1:0] pick_rank();
      int unsigned left;
      int unsigned roll;
      left = (stim_pos + 1 >= stim_size) ? stim_size : stim_size - stim_pos;
      roll = $urandom_range(0, 99);
      if (roll < 80) return RANK_W'($urandom_range(0, left - 1));
      if (roll < 88) return ($urandom_range(0, 1) != 0) ? RANK_W'(left - 1) : '0;
      if (roll < 96 && left <= 1023) return RANK_W'($urandom_range(left, 1023));
      return RANK_W'($urandom_range(0, 1023));
   endfunction

   task automatic send_rank(input logic [RANK_W-1:0] rank);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         idle_cycles(($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3));
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_rank <= rank;
      do @(posedge clock); while (!req_ready);
      track_rank(rank);
   endtask

   task automatic random_phase(input logic [CSR_DATA_W-1:0] data, input int unsigned count);
      set_size(data);
      repeat (count) begin
         if ($urandom_range(0, 49) == 0) wait_quiet();
         send_rank(pick_rank());
      end
   endtask

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // reset size of 1024: top rank, bottom rank, one too large
      send_rank(10'd1023);
      send_rank(10'd0);
      send_rank(10'd1022);
      send_rank(10'd512);

      set_size(32'd2);
      send_rank(10'd0);
      send_rank(10'd1);
      send_rank(10'd2);
      send_rank(10'd1023);

      // sizes below two act as two
      set_size(32'd0);
      send_rank(10'd1);
      set_size(32'd1);
      send_rank(10'd0);

      set_size(32'd3);
      send_rank(10'd2);
      wait_quiet();
      csr_write(SPARE_ADDR, 32'h0000_0005);
      send_rank(10'd1);
      send_rank(10'd0);
      send_rank(10'd0);
      send_rank(10'd3);
      send_rank(10'd1);
      send_rank(10'd2);

      // oversize clamps to the maximum
      set_size(32'd2047);
      send_rank(10'd1023);
      send_rank(10'd1023);

      // upper data bits beyond the register are dropped
      set_size(32'hFFFF_F805);
      send_rank(10'd4);
      send_rank(10'd3);
      send_rank(10'd2);
      send_rank(10'd1);

      random_phase(32'd2, 30);
      random_phase(32'd3, 30);
      random_phase(32'd1024, 60);
      repeat (8) random_phase($urandom_range(4, 16), 25);
      random_phase(32'd0, 10);
      random_phase(32'd1, 10);
      random_phase(32'd2047, 15);
      random_phase(32'd1500, 10);
      wait_quiet();
      csr_write(SPARE_ADDR, $urandom);
      repeat (2) random_phase($urandom_range(17, 100), 40);

      idle_cycles(1);
      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- files.f -----
sv/prd_pkg.sv
sv/prd_ram.sv
sv/permutation_rank_decoder.sv
dv/prd_checker.sv
dv/tb_permutation_rank_decoder.sv
